// File: hdl/axis_angle_to_rotation_matrix_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rotation-vector to rotation-matrix block
// Same-cycle and fixed-delay implication checks on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef AXIS_ANGLE_TO_ROTATION_MATRIX_ASSERT_SVH
`define AXIS_ANGLE_TO_ROTATION_MATRIX_ASSERT_SVH

// same-cycle implication
`define AARM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("aarm: check failed");

// implication after a fixed number of cycles
`define AARM_ASSERT_LAT(lbl, ante, dly, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error("aarm: latency check failed");

`endif

// File: hdl/aarm_pkg.sv
// ----------------------------------------------------------------------------
// aarm_pkg
// Shared constants, types and tables of the rotation matrix pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aarm_pkg;

	localparam int FX                = 30;
	localparam int CORDIC_ITERS      = 30;
	localparam int DIV_STEPS         = FX + 1;
	localparam int SQRT_STEPS        = 16;
	localparam int SQRT_LAT          = SQRT_STEPS + 2;
	localparam int MAT_LAT           = 5;
	localparam int XY_W              = 34;
	localparam int IN_FRAC_BITS_DEF  = 12;
	localparam int OUT_FRAC_BITS_DEF = 14;

	localparam longint PI_FX          = 64'sd3373259426;
	localparam longint HALF_PI_FX     = 64'sd1686629713;
	localparam longint TWO_PI_FX      = 64'sd6746518852;
	localparam longint CORDIC_GAIN_FX = 64'sd652032874;

	localparam logic REG_THRESHOLD = 1'b0;

	typedef struct packed {
		logic valid;
		logic tiny;
	} aarm_ctl_t;

	// number of binary modulo-2pi reduction steps for the largest angle
	function automatic int red_steps(input int in_frac);
		longint unsigned maxq;
		maxq = (64'd65535 << (FX - in_frac)) / TWO_PI_FX;
		return $clog2(maxq + 64'd1);
	endfunction

	// saturated value of +1.0 in the output field
	function automatic logic [15:0] diag_value(input int out_frac);
		longint one;
		one = longint'(1) << out_frac;
		return (one > 32767) ? 16'd32767 : 16'(one);
	endfunction

	function automatic logic [31:0] atan_fx(input int i);
		logic [31:0] r;
		case (i)
			0:       r = 32'd843314856;
			1:       r = 32'd497837829;
			2:       r = 32'd263043836;
			3:       r = 32'd133525158;
			4:       r = 32'd67021686;
			5:       r = 32'd33543515;
			6:       r = 32'd16775850;
			7:       r = 32'd8388437;
			8:       r = 32'd4194282;
			9:       r = 32'd2097149;
			10:      r = 32'd1048575;
			11:      r = 32'd524287;
			12:      r = 32'd262143;
			13:      r = 32'd131071;
			14:      r = 32'd65535;
			15:      r = 32'd32767;
			16:      r = 32'd16383;
			17:      r = 32'd8191;
			18:      r = 32'd4095;
			19:      r = 32'd2047;
			20:      r = 32'd1023;
			21:      r = 32'd511;
			22:      r = 32'd255;
			23:      r = 32'd127;
			24:      r = 32'd63;
			25:      r = 32'd31;
			26:      r = 32'd15;
			27:      r = 32'd7;
			28:      r = 32'd3;
			29:      r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [33:0] rnd30(input logic signed [63:0] v);
		logic signed [63:0] t;
		t = v + (64'sd1 <<< (FX - 1));
		return 34'(t >>> FX);
	endfunction

endpackage

// File: hdl/aarm_sqrt.sv
// ----------------------------------------------------------------------------
// aarm_sqrt
// Squares, sum and a one-bit-per-stage integer square root of the vector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aarm_sqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic signed [15:0] in_x,
	input  logic signed [15:0] in_y,
	input  logic signed [15:0] in_z,
	output logic               out_valid,
	output logic [2:0][15:0]   out_vec,
	output logic [15:0]        out_root
);

	localparam int STEPS = aarm_pkg::SQRT_STEPS;

	logic signed [31:0] px, py, pz;
	logic               vld_s1, vld_s2;
	logic [30:0]        sqx_s1, sqy_s1, sqz_s1;
	logic [2:0][15:0]   vec_s1, vec_s2;
	logic [31:0]        sum_s2;

	logic               vld_s  [0:STEPS];
	logic [16:0]        rem_s  [0:STEPS];
	logic [15:0]        root_s [0:STEPS];
	logic [31:0]        n_s    [0:STEPS];
	logic [2:0][15:0]   vec_s  [0:STEPS];

	assign px = in_x * in_x;
	assign py = in_y * in_y;
	assign pz = in_z * in_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		sqx_s1 <= px[30:0];
		sqy_s1 <= py[30:0];
		sqz_s1 <= pz[30:0];
		vec_s1 <= {in_z, in_y, in_x};
		sum_s2 <= 32'(sqx_s1) + 32'(sqy_s1) + 32'(sqz_s1);
		vec_s2 <= vec_s1;
	end

	assign vld_s[0]  = vld_s2;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign n_s[0]    = sum_s2;
	assign vec_s[0]  = vec_s2;

	for (genvar g = 0; g < STEPS; g++) begin : g_step
		logic [18:0] cur;
		logic [18:0] trial;

		assign cur   = {rem_s[g], n_s[g][31:30]};
		assign trial = {1'b0, root_s[g], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (cur >= trial) begin
				rem_s[g+1]  <= 17'(cur - trial);
				root_s[g+1] <= {root_s[g][14:0], 1'b1};
			end else begin
				rem_s[g+1]  <= cur[16:0];
				root_s[g+1] <= {root_s[g][14:0], 1'b0};
			end
			n_s[g+1]   <= {n_s[g][29:0], 2'b00};
			vec_s[g+1] <= vec_s[g];
		end
	end

	assign out_valid = vld_s[STEPS];
	assign out_vec   = vec_s[STEPS];
	assign out_root  = root_s[STEPS];

endmodule

// File: hdl/aarm_trig.sv
// ----------------------------------------------------------------------------
// aarm_trig
// Angle reduction and CORDIC sine/cosine, with a restoring divider per axis
// lane running alongside in the same stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aarm_trig #(
	parameter int IN_FRAC_BITS = aarm_pkg::IN_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic [2:0][15:0]                 in_vec,
	input  logic [15:0]                      in_ang,
	input  logic [15:0]                      thr,
	output aarm_pkg::aarm_ctl_t              out_ctl,
	output logic [2:0][31:0]                 out_u,
	output logic signed [aarm_pkg::XY_W-1:0] out_sn,
	output logic signed [aarm_pkg::XY_W-1:0] out_cs
);

	localparam int SHL = aarm_pkg::FX - IN_FRAC_BITS;
	localparam int AW  = 16 + SHL;
	localparam int TW  = ((AW > 34) ? AW : 34) + 1;
	localparam int RED = aarm_pkg::red_steps(IN_FRAC_BITS);
	localparam int T   = RED + 2 + aarm_pkg::CORDIC_ITERS;
	localparam int XW  = aarm_pkg::XY_W;
	localparam int DS  = aarm_pkg::DIV_STEPS;

	localparam logic signed [TW-1:0] PI     = TW'(aarm_pkg::PI_FX);
	localparam logic signed [TW-1:0] HALF   = TW'(aarm_pkg::HALF_PI_FX);
	localparam logic signed [TW-1:0] TWO_PI = TW'(aarm_pkg::TWO_PI_FX);
	localparam logic signed [XW-1:0] GAIN   = XW'(aarm_pkg::CORDIC_GAIN_FX);

	logic                 vld_s  [0:T];
	logic                 tiny_s [0:T];
	logic [2:0]           sgn_s  [0:T];
	logic [15:0]          ang_s  [0:T];
	logic signed [TW-1:0] z_s    [0:T];
	logic signed [XW-1:0] x_s    [0:T];
	logic signed [XW-1:0] y_s    [0:T];
	logic                 ncos_s [0:T];
	logic [15:0]          rem_s  [0:T][0:2];
	logic [DS-1:0]        nl_s   [0:T][0:2];
	logic [DS-1:0]        q_s    [0:T][0:2];

	logic [AW-1:0] ang30;

	assign ang30     = {in_ang, {SHL{1'b0}}};
	assign vld_s[0]  = in_valid;
	assign tiny_s[0] = (in_ang == 16'd0) || (in_ang <= thr);
	assign ang_s[0]  = in_ang;
	assign z_s[0]    = TW'(ang30);
	assign x_s[0]    = '0;
	assign y_s[0]    = '0;
	assign ncos_s[0] = 1'b0;

	for (genvar l = 0; l < 3; l++) begin : g_init
		logic [15:0] mag;
		logic [46:0] num;

		assign mag          = in_vec[l][15] ? 16'(-in_vec[l]) : in_vec[l];
		assign num          = {1'b0, mag, 30'd0} + 47'(in_ang[15:1]);
		assign sgn_s[0][l]  = in_vec[l][15];
		assign rem_s[0][l]  = num[46:31];
		assign nl_s[0][l]   = num[30:0];
		assign q_s[0][l]    = '0;
	end

	for (genvar g = 0; g < T; g++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			tiny_s[g+1] <= tiny_s[g];
			sgn_s[g+1]  <= sgn_s[g];
			ang_s[g+1]  <= ang_s[g];
		end

		if (g < RED) begin : g_red
			localparam logic signed [TW-1:0] SUB = TWO_PI <<< (RED - 1 - g);

			always_ff @(posedge clk) begin
				if (z_s[g] >= SUB) begin
					z_s[g+1] <= z_s[g] - SUB;
				end else begin
					z_s[g+1] <= z_s[g];
				end
				x_s[g+1]    <= x_s[g];
				y_s[g+1]    <= y_s[g];
				ncos_s[g+1] <= ncos_s[g];
			end
		end else if (g == RED) begin : g_wrap
			always_ff @(posedge clk) begin
				if (z_s[g] > PI) begin
					z_s[g+1] <= z_s[g] - TWO_PI;
				end else begin
					z_s[g+1] <= z_s[g];
				end
				x_s[g+1]    <= x_s[g];
				y_s[g+1]    <= y_s[g];
				ncos_s[g+1] <= ncos_s[g];
			end
		end else if (g == RED + 1) begin : g_fold
			always_ff @(posedge clk) begin
				if (z_s[g] > HALF) begin
					z_s[g+1]    <= PI - z_s[g];
					ncos_s[g+1] <= 1'b1;
				end else if (z_s[g] < -HALF) begin
					z_s[g+1]    <= -PI - z_s[g];
					ncos_s[g+1] <= 1'b1;
				end else begin
					z_s[g+1]    <= z_s[g];
					ncos_s[g+1] <= 1'b0;
				end
				x_s[g+1] <= GAIN;
				y_s[g+1] <= '0;
			end
		end else begin : g_cordic
			localparam int I = g - RED - 2;
			localparam logic signed [TW-1:0] ATAN = TW'(aarm_pkg::atan_fx(I));
			logic signed [XW-1:0] xs, ys;

			assign xs = x_s[g] >>> I;
			assign ys = y_s[g] >>> I;

			always_ff @(posedge clk) begin
				if (!z_s[g][TW-1]) begin
					x_s[g+1] <= x_s[g] - ys;
					y_s[g+1] <= y_s[g] + xs;
					z_s[g+1] <= z_s[g] - ATAN;
				end else begin
					x_s[g+1] <= x_s[g] + ys;
					y_s[g+1] <= y_s[g] - xs;
					z_s[g+1] <= z_s[g] + ATAN;
				end
				ncos_s[g+1] <= ncos_s[g];
			end
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			if (g < DS) begin : g_div
				logic [16:0] trial;

				assign trial = {rem_s[g][l], nl_s[g][l][DS-1]};

				always_ff @(posedge clk) begin
					if (trial >= {1'b0, ang_s[g]}) begin
						rem_s[g+1][l] <= 16'(trial - {1'b0, ang_s[g]});
						q_s[g+1][l]   <= {q_s[g][l][DS-2:0], 1'b1};
					end else begin
						rem_s[g+1][l] <= trial[15:0];
						q_s[g+1][l]   <= {q_s[g][l][DS-2:0], 1'b0};
					end
					nl_s[g+1][l] <= {nl_s[g][l][DS-2:0], 1'b0};
				end
			end else begin : g_hold
				always_ff @(posedge clk) begin
					rem_s[g+1][l] <= rem_s[g][l];
					q_s[g+1][l]   <= q_s[g][l];
					nl_s[g+1][l]  <= nl_s[g][l];
				end
			end
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_out
		logic signed [31:0] mag_u;

		assign mag_u    = $signed({1'b0, q_s[T][l]});
		assign out_u[l] = sgn_s[T][l] ? 32'(-mag_u) : 32'(mag_u);
	end

	assign out_ctl.valid = vld_s[T];
	assign out_ctl.tiny  = tiny_s[T];
	assign out_sn        = y_s[T];
	assign out_cs        = ncos_s[T] ? -x_s[T] : x_s[T];

endmodule

// File: hdl/aarm_matrix.sv
// ----------------------------------------------------------------------------
// aarm_matrix
// Rodrigues assembly: K*K terms, sin/(1-cos) products, rounding and
// saturation of the nine entries, identity override for small angles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aarm_matrix #(
	parameter int OUT_FRAC_BITS = aarm_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  aarm_pkg::aarm_ctl_t              in_ctl,
	input  logic [2:0][31:0]                 in_u,
	input  logic signed [aarm_pkg::XY_W-1:0] in_sn,
	input  logic signed [aarm_pkg::XY_W-1:0] in_cs,
	output logic                             done,
	output logic                             is_identity,
	output logic [8:0][15:0]                 mat
);

	localparam int XW = aarm_pkg::XY_W;
	localparam int EW = 72;
	localparam int SH = 2 * aarm_pkg::FX - OUT_FRAC_BITS;
	localparam logic signed [EW-1:0] HALF_LSB = 72'sd1 <<< (SH - 1);
	localparam logic signed [EW-1:0] ONE60    = 72'sd1 <<< (2 * aarm_pkg::FX);
	localparam longint ONE_O = longint'(1) << OUT_FRAC_BITS;
	localparam longint HI    = (ONE_O > 32767) ? 32767 : ONE_O;
	localparam longint LO    = (ONE_O > 32768) ? -32768 : -ONE_O;
	localparam logic [15:0] DIAG = aarm_pkg::diag_value(OUT_FRAC_BITS);
	localparam logic signed [XW:0] ONE30 = (XW + 1)'(64'sd1 <<< aarm_pkg::FX);

	function automatic logic [15:0] sat_entry(input logic signed [EW-1:0] e);
		logic signed [EW-1:0] r;
		r = (e + HALF_LSB) >>> SH;
		if (r > HI) begin
			return 16'(HI);
		end else if (r < LO) begin
			return 16'(LO);
		end
		return r[15:0];
	endfunction

	logic signed [31:0] ua, ub, uc;

	aarm_pkg::aarm_ctl_t  ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic signed [63:0]   paa_s1, pbb_s1, pcc_s1, pab_s1, pac_s1, pbc_s1;
	logic signed [31:0]   a_s1, b_s1, c_s1, a_s2, b_s2, c_s2;
	logic signed [XW-1:0] sn_s1, sn_s2;
	logic signed [XW:0]   omc_s1, omc_s2;
	logic signed [33:0]   m00_s2, m11_s2, m22_s2, mab_s2, mac_s2, mbc_s2;
	logic signed [EW-1:0] sa_s3, sb_s3, sc_s3;
	logic signed [EW-1:0] o00_s3, o11_s3, o22_s3, oab_s3, oac_s3, obc_s3;
	logic signed [EW-1:0] e_s4 [0:8];
	logic                 vld_s5, id_s5;
	logic [8:0][15:0]     mat_s5;

	assign ua = $signed(in_u[0]);
	assign ub = $signed(in_u[1]);
	assign uc = $signed(in_u[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			vld_s5 <= 1'b0;
			id_s5  <= 1'b0;
		end else begin
			ctl_s1 <= in_ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			vld_s5 <= ctl_s4.valid;
			id_s5  <= ctl_s4.valid && ctl_s4.tiny;
		end
	end

	always_ff @(posedge clk) begin
		paa_s1 <= ua * ua;
		pbb_s1 <= ub * ub;
		pcc_s1 <= uc * uc;
		pab_s1 <= ua * ub;
		pac_s1 <= ua * uc;
		pbc_s1 <= ub * uc;
		a_s1   <= ua;
		b_s1   <= ub;
		c_s1   <= uc;
		sn_s1  <= in_sn;
		omc_s1 <= ONE30 - in_cs;

		m00_s2 <= aarm_pkg::rnd30(-(pbb_s1 + pcc_s1));
		m11_s2 <= aarm_pkg::rnd30(-(pcc_s1 + paa_s1));
		m22_s2 <= aarm_pkg::rnd30(-(pbb_s1 + paa_s1));
		mab_s2 <= aarm_pkg::rnd30(pab_s1);
		mac_s2 <= aarm_pkg::rnd30(pac_s1);
		mbc_s2 <= aarm_pkg::rnd30(pbc_s1);
		a_s2   <= a_s1;
		b_s2   <= b_s1;
		c_s2   <= c_s1;
		sn_s2  <= sn_s1;
		omc_s2 <= omc_s1;

		sa_s3  <= sn_s2 * a_s2;
		sb_s3  <= sn_s2 * b_s2;
		sc_s3  <= sn_s2 * c_s2;
		o00_s3 <= omc_s2 * m00_s2;
		o11_s3 <= omc_s2 * m11_s2;
		o22_s3 <= omc_s2 * m22_s2;
		oab_s3 <= omc_s2 * mab_s2;
		oac_s3 <= omc_s2 * mac_s2;
		obc_s3 <= omc_s2 * mbc_s2;

		e_s4[0] <= ONE60 + o00_s3;
		e_s4[1] <= oab_s3 - sc_s3;
		e_s4[2] <= oac_s3 + sb_s3;
		e_s4[3] <= oab_s3 + sc_s3;
		e_s4[4] <= ONE60 + o11_s3;
		e_s4[5] <= obc_s3 - sa_s3;
		e_s4[6] <= oac_s3 - sb_s3;
		e_s4[7] <= obc_s3 + sa_s3;
		e_s4[8] <= ONE60 + o22_s3;
	end

	for (genvar k = 0; k < 9; k++) begin : g_entry
		localparam logic [15:0] ID_VAL = ((k % 4) == 0) ? DIAG : 16'd0;

		always_ff @(posedge clk) begin
			mat_s5[k] <= ctl_s4.tiny ? ID_VAL : sat_entry(e_s4[k]);
		end
	end

	assign done        = vld_s5;
	assign is_identity = id_s5;
	assign mat         = mat_s5;

endmodule

// File: hdl/axis_angle_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// axis_angle_to_rotation_matrix
// Rotation vector (Q3.12) to 3x3 rotation matrix (Q1.14), Rodrigues form.
// ----------------------------------------------------------------------------
// Usage:
//   A word (axis_x/y/z) is taken on every clock edge with start high; busy
//   is always low, so one vector per cycle is sustained.
//   Each result word (m00..m22, is_identity) shows for one cycle with done.
//   Stages: squares and the bit-serial root, the reduction steps, one stage
//   per CORDIC iteration and divider bit, and the matrix multiply/round.
//   Results leave in input order; the receiver cannot stall the output.
//   small_angle_threshold sits at APB address 0; write it while idle.
//   Reset clears all valid bits and the threshold; in-flight words are lost.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module axis_angle_to_rotation_matrix #(
	parameter int IN_FRAC_BITS  = aarm_pkg::IN_FRAC_BITS_DEF,
	parameter int OUT_FRAC_BITS = aarm_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	output logic               done,
	output logic signed [15:0] m00,
	output logic signed [15:0] m01,
	output logic signed [15:0] m02,
	output logic signed [15:0] m10,
	output logic signed [15:0] m11,
	output logic signed [15:0] m12,
	output logic signed [15:0] m20,
	output logic signed [15:0] m21,
	output logic signed [15:0] m22,
	output logic               is_identity,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int LAT = aarm_pkg::SQRT_LAT + aarm_pkg::red_steps(IN_FRAC_BITS) + 2
		+ aarm_pkg::CORDIC_ITERS + aarm_pkg::MAT_LAT;
	localparam logic [15:0] DIAG = aarm_pkg::diag_value(OUT_FRAC_BITS);

	logic [15:0]                      thr_q;
	logic                             sq_valid;
	logic [2:0][15:0]                 sq_vec;
	logic [15:0]                      sq_root;
	aarm_pkg::aarm_ctl_t              tr_ctl;
	logic [2:0][31:0]                 tr_u;
	logic signed [aarm_pkg::XY_W-1:0] tr_sn, tr_cs;
	logic [8:0][15:0]                 mat;

	assign busy   = 1'b0;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == aarm_pkg::REG_THRESHOLD) begin
			thr_q <= pwdata[15:0];
		end
	end

	assign prdata = (paddr[2] == aarm_pkg::REG_THRESHOLD) ? {16'd0, thr_q} : 32'd0;

	aarm_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.in_x      (axis_x),
		.in_y      (axis_y),
		.in_z      (axis_z),
		.out_valid (sq_valid),
		.out_vec   (sq_vec),
		.out_root  (sq_root)
	);

	aarm_trig #(
		.IN_FRAC_BITS (IN_FRAC_BITS)
	) u_trig (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sq_valid),
		.in_vec   (sq_vec),
		.in_ang   (sq_root),
		.thr      (thr_q),
		.out_ctl  (tr_ctl),
		.out_u    (tr_u),
		.out_sn   (tr_sn),
		.out_cs   (tr_cs)
	);

	aarm_matrix #(
		.OUT_FRAC_BITS (OUT_FRAC_BITS)
	) u_matrix (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ctl      (tr_ctl),
		.in_u        (tr_u),
		.in_sn       (tr_sn),
		.in_cs       (tr_cs),
		.done        (done),
		.is_identity (is_identity),
		.mat         (mat)
	);

	assign m00 = mat[0];
	assign m01 = mat[1];
	assign m02 = mat[2];
	assign m10 = mat[3];
	assign m11 = mat[4];
	assign m12 = mat[5];
	assign m20 = mat[6];
	assign m21 = mat[7];
	assign m22 = mat[8];

`include "axis_angle_to_rotation_matrix_assert.svh"

	`AARM_ASSERT_LAT(a_latency, start && !busy, LAT, done)
	`AARM_ASSERT_NOW(a_id_done, is_identity, done)
	`AARM_ASSERT_NOW(a_id_diag, done && is_identity, m00 == DIAG && m11 == DIAG && m22 == DIAG)
	`AARM_ASSERT_NOW(a_id_off, done && is_identity, {m01, m02, m10, m12, m20, m21} == 96'd0)

endmodule

// File: test/axis_angle_to_rotation_matrix_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axis_angle_to_rotation_matrix_tb
// Sends rotation vectors into the block and checks every matrix word that
// comes back against a bit-exact software model of the Rodrigues pipeline
// (integer root, fixed-point division, CORDIC sine/cosine, rounding and
// saturation). The test changes the small-angle threshold between phases.
// ----------------------------------------------------------------------------

module axis_angle_to_rotation_matrix_tb;

	localparam int IN_FRAC      = 12;
	localparam int OUT_FRAC     = 14;
	localparam int N_RANDOM     = 1600;
	localparam int DRAIN_CYCLES = 80;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct {
		logic signed [15:0] m [9];
		logic               ident;
	} matrix_word_t;

	// ------------------------------------------------------------------------
	// expected matrix words, in input order
	// ------------------------------------------------------------------------
	class matrix_scoreboard;
		matrix_word_t pending[$];
		int           errors;
		longint unsigned threshold;

		function new();
			errors    = 0;
			threshold = 0;
		endfunction

		function automatic longint srshift(longint v, int s);
			return v >>> s;
		endfunction

		function automatic longint round_to(longint v, int s);
			return (v + (longint'(1) << (s - 1))) >>> s;
		endfunction

		function automatic longint unsigned int_sqrt(longint unsigned n);
			longint unsigned res, b;
			res = 0;
			b   = 64'd1 << 62;
			while (b > n)
				b >>= 2;
			while (b != 0) begin
				if (n >= res + b) begin
					n  -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function automatic logic signed [15:0] saturate(longint v);
			longint one;
			one = longint'(1) << OUT_FRAC;
			if (v > one) v = one;
			if (v < -one) v = -one;
			if (v > 32767) v = 32767;
			if (v < -32768) v = -32768;
			return 16'(v);
		endfunction

		function automatic void sin_cos(longint unsigned ang, output longint sn,
				output longint cs);
			longint t, x, y, z, dx, dy;
			bit     flip;
			t    = longint'(ang % longint'(aarm_pkg::TWO_PI_FX));
			flip = 0;
			if (t > aarm_pkg::PI_FX)
				t -= aarm_pkg::TWO_PI_FX;
			if (t > aarm_pkg::HALF_PI_FX) begin
				t    = aarm_pkg::PI_FX - t;
				flip = 1;
			end else if (t < -aarm_pkg::HALF_PI_FX) begin
				t    = -aarm_pkg::PI_FX - t;
				flip = 1;
			end
			x = aarm_pkg::CORDIC_GAIN_FX;
			y = 0;
			z = t;
			for (int i = 0; i < 30; i++) begin
				dx = srshift(y, i);
				dy = srshift(x, i);
				if (z >= 0) begin
					x -= dx; y += dy; z -= longint'(aarm_pkg::atan_fx(i));
				end else begin
					x += dx; y -= dy; z += longint'(aarm_pkg::atan_fx(i));
				end
			end
			sn = y;
			cs = flip ? -x : x;
		endfunction

		function automatic void note_vector(logic signed [15:0] ax,
				logic signed [15:0] ay, logic signed [15:0] az);
			matrix_word_t    w;
			longint          v[3], u[3], k[3][3], kk[3][3];
			longint          sn, cs, omc, acc, e;
			longint unsigned sum, ang, mag;
			v[0] = ax; v[1] = ay; v[2] = az;
			sum = 0;
			for (int i = 0; i < 3; i++)
				sum += longint'(v[i] * v[i]);
			ang = int_sqrt(sum);
			if (ang == 0 || ang <= threshold) begin
				for (int i = 0; i < 9; i++)
					w.m[i] = (i % 4 == 0) ? saturate(longint'(1) << OUT_FRAC) : 16'sd0;
				w.ident = 1'b1;
				pending.insert(pending.size(), w);
				return;
			end
			for (int i = 0; i < 3; i++) begin
				mag  = longint'(v[i] < 0 ? -v[i] : v[i]) << 30;
				u[i] = longint'((mag + ang / 2) / ang);
				if (v[i] < 0) u[i] = -u[i];
			end
			k[0][0] = 0;     k[0][1] = -u[2]; k[0][2] = u[1];
			k[1][0] = u[2];  k[1][1] = 0;     k[1][2] = -u[0];
			k[2][0] = -u[1]; k[2][1] = u[0];  k[2][2] = 0;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					acc = 0;
					for (int n = 0; n < 3; n++)
						acc += k[i][n] * k[n][j];
					kk[i][j] = round_to(acc, 30);
				end
			sin_cos(ang << (30 - IN_FRAC), sn, cs);
			omc = (longint'(1) << 30) - cs;
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					e  = (i == j) ? (longint'(1) << 60) : 0;
					e += sn * k[i][j] + omc * kk[i][j];
					w.m[i * 3 + j] = saturate(round_to(e, 60 - OUT_FRAC));
				end
			w.ident = 1'b0;
			pending.insert(pending.size(), w);
		endfunction

		function automatic void check_word(matrix_word_t got);
			matrix_word_t want;
			string        names[9] = '{"m00", "m01", "m02", "m10", "m11", "m12",
				"m20", "m21", "m22"};
			if (pending.size() == 0) begin
				$error("matrix word with none expected");
				errors++;
				return;
			end
			want = pending.pop_front();
			for (int i = 0; i < 9; i++)
				if (got.m[i] !== want.m[i]) begin
					$error("%s: expected %0d, got %0d", names[i], want.m[i], got.m[i]);
					errors++;
				end
			if (got.ident !== want.ident) begin
				$error("is_identity: expected %0d, got %0d", want.ident, got.ident);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic signed [15:0] axis_x = '0, axis_y = '0, axis_z = '0;
	logic               done;
	logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic               is_identity;
	logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	matrix_scoreboard sb = new();
	longint           cycles = 0;
	int               quiet_lo, quiet_hi;
	int               sent;

	axis_angle_to_rotation_matrix DUT (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		matrix_word_t w;
		cycles++;
		if (done) begin
			w.m = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
			w.ident = is_identity;
			sb.check_word(w);
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("axis_angle_to_rotation_matrix regression: fail");
			$finish;
		end
	end

	task automatic write_threshold(logic [15:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= 3'(aarm_pkg::REG_THRESHOLD) << 2;
		pwdata  <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.threshold = value;
	endtask

	task automatic send_vector(logic signed [15:0] x, logic signed [15:0] y,
			logic signed [15:0] z);
		if (!(sent >= quiet_lo && sent < quiet_hi)) begin
			while ($urandom_range(99) < 12) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start  <= 1'b1;
		axis_x <= x;
		axis_y <= y;
		axis_z <= z;
		do @(posedge clk); while (busy);
		sb.note_vector(x, y, z);
		sent++;
	endtask

	task automatic settle();
		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_comp(int scale);
		case (scale)
			0:       return 16'($signed($urandom_range(0, 400)) - 200);
			1:       return 16'($signed($urandom_range(0, 16384)) - 8192);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [15:0] th_list[5];
		th_list  = '{16'd0, 16'd100, 16'd4096, 16'd65535, 16'd30};
		sent     = 0;
		quiet_lo = 300;
		quiet_hi = 600;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, axes, zero, tiny
		send_vector(0, 0, 0);
		send_vector(1, 0, 0);
		send_vector(0, -1, 0);
		send_vector(16'sh7fff, 0, 0);
		send_vector(-16'sh8000, 0, 0);
		send_vector(0, 16'sh7fff, 0);
		send_vector(0, 0, -16'sh8000);
		send_vector(-16'sh8000, -16'sh8000, -16'sh8000);
		send_vector(16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_vector(16'sh7fff, -16'sh8000, 16'sh7fff);
		send_vector(12868, 0, 0);
		send_vector(0, 0, 6434);
		send_vector(0, 25736, 0);
		send_vector(4096, 4096, 4096);
		send_vector(-4096, 2048, 1024);
		send_vector(16'sh5555, -16'sh2aab, 16'sh00ff);
		settle();

		for (int ph = 0; ph < 5; ph++) begin
			write_threshold(th_list[ph]);
			send_vector(0, 0, 0);
			send_vector(16'(th_list[ph] > 32767 ? 32767 : th_list[ph]), 0, 0);
			send_vector(16'(th_list[ph] >= 32767 ? 32767 : th_list[ph] + 1), 0, 0);
			for (int i = 0; i < N_RANDOM / 5; i++)
				send_vector(rand_comp($urandom_range(2)), rand_comp($urandom_range(2)),
					rand_comp($urandom_range(2)));
			settle();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("axis_angle_to_rotation_matrix regression: pass");
		else
			$display("axis_angle_to_rotation_matrix regression: fail");
		$finish;
	end

endmodule
